/* src/deque_with_running_average_unit_defines.svh */
// ---------------------------------------------------------------------------
// Deque with running average: assertion macros
// Clocked assertion wrappers shared by the RTL. Define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_RUNNING_AVERAGE_UNIT_DEFINES_SVH
`define DEQUE_WITH_RUNNING_AVERAGE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define DQAVG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define DQAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQAVG_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/dqavg_pkg.sv */
// ---------------------------------------------------------------------------
// dqavg_pkg
// Types and constants shared by the deque with running average.
// ---------------------------------------------------------------------------
package dqavg_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OP_W            = 3;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_LEFT  = 3'd0,
        OP_PUSH_RIGHT = 3'd1,
        OP_POP_LEFT   = 3'd2,
        OP_POP_RIGHT  = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_AVERAGE    = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_DIV,
        S_DONE
    } t_state;

    // Handshake status of a serial unit back to the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* src/dqavg_store.sv */
// ---------------------------------------------------------------------------
// dqavg_store
// Ring element memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module dqavg_store #(
    parameter int DEPTH       = dqavg_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = dqavg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [VALUE_WIDTH-1:0]   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [VALUE_WIDTH-1:0]   o_rdata
);

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dqavg_serial_acc.sv */
// ---------------------------------------------------------------------------
// dqavg_serial_acc
// Running sum held in a shift register; add or subtract one bit per cycle.
// ---------------------------------------------------------------------------
module dqavg_serial_acc #(
    parameter int VALUE_WIDTH = dqavg_pkg::VALUE_WIDTH_DEF,
    parameter int SUM_W       = dqavg_pkg::VALUE_WIDTH_DEF + $clog2(dqavg_pkg::DEPTH_DEF)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_sub,
    input  logic                    i_clear,
    input  logic [VALUE_WIDTH-1:0]  i_operand,
    output logic [SUM_W-1:0]        o_sum,
    output dqavg_pkg::t_unit_stat   o_stat
);

    import dqavg_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_opnd;
    logic              r_carry;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W-1:0]  w_ext;
    logic              w_bit;
    logic              w_carry;

    assign w_ext   = {{(SUM_W-VALUE_WIDTH){i_operand[VALUE_WIDTH-1]}}, i_operand};
    // full adder on the low bits
    assign w_bit   = r_sum[0] ^ r_opnd[0] ^ r_carry;
    assign w_carry = (r_sum[0] & r_opnd[0]) | (r_carry & (r_sum[0] ^ r_opnd[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_clear) begin
                r_sum <= '0;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_sum  <= {w_bit, r_sum[SUM_W-1:1]};
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // subtract as add of the inverted operand with carry in set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_opnd  <= i_sub ? ~w_ext : w_ext;
            r_carry <= i_sub;
        end else if (r_busy) begin
            r_opnd  <= {1'b0, r_opnd[SUM_W-1:1]};
            r_carry <= w_carry;
        end
    end

    assign o_sum       = r_sum;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* src/dqavg_serial_div.sv */
// ---------------------------------------------------------------------------
// dqavg_serial_div
// Restoring divider: one quotient bit per cycle, truncated toward zero.
// ---------------------------------------------------------------------------
module dqavg_serial_div #(
    parameter int VALUE_WIDTH = dqavg_pkg::VALUE_WIDTH_DEF,
    parameter int SUM_W       = dqavg_pkg::VALUE_WIDTH_DEF + $clog2(dqavg_pkg::DEPTH_DEF),
    parameter int CNT_W       = $clog2(dqavg_pkg::DEPTH_DEF + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SUM_W-1:0]        i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic [VALUE_WIDTH-1:0]  o_quotient,
    output dqavg_pkg::t_unit_stat   o_stat
);

    import dqavg_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [CNT_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [CNT_W-1:0]       r_div;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic                   r_busy;
    logic                   r_done;
    logic [SUM_W-1:0]       w_mag;
    logic [CNT_W:0]         w_trial;
    logic [CNT_W:0]         w_diff;
    logic                   w_ge;
    logic [VALUE_WIDTH-1:0] w_qlow;

    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // dividend bits leave at the top as quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign w_qlow      = r_quo[VALUE_WIDTH-1:0];
    assign o_quotient  = r_neg ? (~w_qlow + VALUE_WIDTH'(1)) : w_qlow;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* src/deque_with_running_average_unit.sv */
// ---------------------------------------------------------------------------
// deque_with_running_average_unit
// Push runs the bit-serial sum update and average the one-bit-per-cycle divider
// before the result strobe. Pop first reads the element from memory, then runs
// the sum update; clear and errors go straight to the done state.
// A new beat is taken the cycle after the strobe. Synchronous active-low reset
// empties the deque and zeroes the sum; the element memory is not cleared.
// ---------------------------------------------------------------------------
`include "deque_with_running_average_unit_defines.svh"

module deque_with_running_average_unit #(
    parameter int DEPTH       = dqavg_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = dqavg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dqavg_pkg::OP_W-1:0]          i_op,
    input  logic signed [VALUE_WIDTH-1:0]       i_value,
    output logic                                o_done,
    output logic [dqavg_pkg::STATUS_W-1:0]      o_status,
    output logic [dqavg_pkg::COUNT_OUT_W-1:0]   o_count,
    output logic signed [VALUE_WIDTH-1:0]       o_average
);

    import dqavg_pkg::*;

    // Ring index, index with wrap headroom, element count and sum widths
    localparam int IDX_W = $clog2(DEPTH);
    localparam int PTR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = VALUE_WIDTH + $clog2(DEPTH);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_left, n_left;
    logic [CNT_W-1:0]       r_count, n_count;
    t_status                r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_avg, n_avg;

    t_op                    w_op;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic [IDX_W-1:0]       w_left_dec;
    logic [IDX_W-1:0]       w_left_inc;
    logic [IDX_W-1:0]       w_right_pos;
    logic [IDX_W-1:0]       w_last_pos;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;

    logic                   w_mem_we;
    logic                   w_mem_re;
    logic [IDX_W-1:0]       w_waddr;
    logic [IDX_W-1:0]       w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic                   w_acc_start;
    logic                   w_acc_sub;
    logic                   w_acc_clear;
    logic [VALUE_WIDTH-1:0] w_acc_opnd;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_div_start;
    logic [VALUE_WIDTH-1:0] w_quotient;
    t_unit_stat             w_acc_stat;
    t_unit_stat             w_div_stat;

    // Fold a position below twice the depth back into the ring
    function automatic logic [IDX_W-1:0] f_wrap(input logic [PTR_W-1:0] pos);
        logic [PTR_W-1:0] folded;
        folded = (pos >= PTR_W'(DEPTH)) ? (pos - PTR_W'(DEPTH)) : pos;
        return folded[IDX_W-1:0];
    endfunction

    // ---- decode ------------------------------------------------------------
    assign w_op     = t_op'(i_op);
    assign w_accept = start && (r_state == S_IDLE);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    // Ring positions: new left slot, slot after left, first free on the
    // right, and the rightmost element
    assign w_left_dec  = (r_left == '0) ? IDX_W'(DEPTH - 1) : (r_left - IDX_W'(1));
    assign w_left_inc  = f_wrap({1'b0, r_left} + PTR_W'(1));
    assign w_right_pos = f_wrap({1'b0, r_left} + PTR_W'(r_count));
    assign w_last_pos  = f_wrap({1'b0, r_left} + PTR_W'(r_count) - PTR_W'(1));

    // ---- next state ----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_PUSH_LEFT, OP_PUSH_RIGHT: n_state = w_full ? S_DONE : S_ACC;
                        OP_POP_LEFT, OP_POP_RIGHT:   n_state = w_empty ? S_DONE : S_READ;
                        OP_AVERAGE:                  n_state = w_empty ? S_DONE : S_DIV;
                        default:                     n_state = S_DONE;
                    endcase
                end
            end
            S_READ: n_state = S_ACC;
            S_ACC: begin
                if (w_acc_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- control outputs -----------------------------------------------------
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_done      = (r_state == S_DONE);
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_acc_start = 1'b0;
        w_acc_sub   = 1'b0;
        w_acc_clear = 1'b0;
        w_div_start = 1'b0;
        w_acc_opnd  = i_value;
        if (w_accept) begin
            unique case (w_op)
                OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
                    w_mem_we    = !w_full;
                    w_acc_start = !w_full;
                end
                OP_POP_LEFT, OP_POP_RIGHT: w_mem_re    = !w_empty;
                OP_CLEAR:                  w_acc_clear = 1'b1;
                OP_AVERAGE:                w_div_start = !w_empty;
                default: ;
            endcase
        end
        // popped element is back from memory: take it off the sum
        if (r_state == S_READ) begin
            w_acc_start = 1'b1;
            w_acc_sub   = 1'b1;
            w_acc_opnd  = w_rdata;
        end
    end

    assign w_waddr = (w_op == OP_PUSH_LEFT) ? w_left_dec : w_right_pos;
    assign w_raddr = (w_op == OP_POP_LEFT) ? r_left : w_last_pos;

    // ---- deque bookkeeping and result ----------------------------------------
    always_comb begin
        n_left   = r_left;
        n_count  = r_count;
        n_status = r_status;
        n_avg    = r_avg;
        if (w_accept) begin
            n_status = ST_OK;
            n_avg    = '0;
            unique case (w_op)
                OP_PUSH_LEFT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_left  = w_left_dec;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_PUSH_RIGHT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP_LEFT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_left  = w_left_inc;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_POP_RIGHT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_left  = '0;
                    n_count = '0;
                end
                OP_AVERAGE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end
                end
                default: ;
            endcase
        end
        // capture the mean as the divider finishes
        if ((r_state == S_DIV) && w_div_stat.done) begin
            n_avg = w_quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

    // result payload: held through the strobe cycle
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_avg    <= n_avg;
    end

    // ---- datapath units ------------------------------------------------------
    dqavg_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dqavg_serial_acc #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .SUM_W       (SUM_W)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc_start),
        .i_sub     (w_acc_sub),
        .i_clear   (w_acc_clear),
        .i_operand (w_acc_opnd),
        .o_sum     (w_sum),
        .o_stat    (w_acc_stat)
    );

    dqavg_serial_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (r_count),
        .o_quotient (w_quotient),
        .o_stat     (w_div_stat)
    );

    // ---- result ports ----------------------------------------------------------
    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};
    assign o_count     = w_count_ext[COUNT_OUT_W-1:0];
    assign o_status    = r_status;
    assign o_average   = r_avg;

    // ---- assertions ------------------------------------------------------------
    `DQAVG_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `DQAVG_ASSERT(a_units_exclusive, i_clk, i_rst_n, !(w_acc_stat.busy && w_div_stat.busy), "overlap")
    `DQAVG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "beat taken but not busy")
    `DQAVG_ASSERT_NEXT(a_done_release, i_clk, i_rst_n, o_done, !busy, "still busy after result")

endmodule
